// ===== rtl/angles_to_ray_point_macros.svh =====
// Assertion macros shared by the ray point RTL.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef ANGLES_TO_RAY_POINT_MACROS_SVH
`define ANGLES_TO_RAY_POINT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ATRP_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define ATRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/atrp_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the ray point block.
// No dependencies.
package atrp_pkg;

  localparam int ANGLE_W            = 17;
  localparam int CORDIC_STAGES_DEF  = 16;
  localparam int COORD_WIDTH_DEF    = 32;
  localparam int ATAN_ENTRIES       = 24;

  // CORDIC datapath widths (Q2.30 values with headroom, phase in 2^-32 turns)
  localparam int XW     = 34;
  localparam int ZW     = 34;
  localparam int PHASE_W = 32;
  localparam int DIR_W  = 32;

  // Angle to phase conversion: q = floor((mag * 2^21 + 22) / 45)
  localparam int MAG_W     = ANGLE_W;
  localparam int QA_W      = 11;
  localparam int QB_W      = 6;
  localparam int QLO_W     = 21;
  localparam int QN_W      = QB_W + QLO_W;
  localparam int RECA_W    = 18;
  localparam int RECB_W    = 28;
  localparam int RECA_SH   = 23;
  localparam int RECB_SH   = 33;
  localparam logic [RECA_W-1:0] REC45_A = RECA_W'(186414);
  localparam logic [RECB_W-1:0] REC45_B = RECB_W'(190887436);
  localparam int DIV45     = 45;
  localparam int ROUND45   = 22;

  localparam logic [PHASE_W-1:0] PHASE_QUARTER = 32'h4000_0000;
  localparam logic [PHASE_W-1:0] PHASE_HALF    = 32'h8000_0000;

  localparam int GAIN_Q30 = 652032874;
  localparam int HALF_Q30 = 1 << 29;

  // Folded phase of one angle
  typedef struct packed {
    logic signed [PHASE_W-1:0] z;
    logic                      flip;
  } rot_t;

  // Raw CORDIC result of one angle, negation still pending
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic                 flip;
  } cs_t;

  // atan(2^-i) in 2^-32 turns, rounded to nearest
  function automatic logic [PHASE_W-1:0] atan_turn(input int unsigned idx);
    logic [PHASE_W-1:0] r;
    case (idx)
      0:       r = 32'h2000_0000;
      1:       r = 32'h12E4_051E;
      2:       r = 32'h09FB_385B;
      3:       r = 32'h0511_11D4;
      4:       r = 32'h028B_0D43;
      5:       r = 32'h0145_D7E1;
      6:       r = 32'h00A2_F61E;
      7:       r = 32'h0051_7C55;
      8:       r = 32'h0028_BE53;
      9:       r = 32'h0014_5F2F;
      10:      r = 32'h000A_2F98;
      11:      r = 32'h0005_17CC;
      12:      r = 32'h0002_8BE6;
      13:      r = 32'h0001_45F3;
      14:      r = 32'h0000_A2F9;
      15:      r = 32'h0000_517D;
      16:      r = 32'h0000_28BE;
      17:      r = 32'h0000_145F;
      18:      r = 32'h0000_0A30;
      19:      r = 32'h0000_0518;
      20:      r = 32'h0000_028C;
      21:      r = 32'h0000_0146;
      22:      r = 32'h0000_00A3;
      23:      r = 32'h0000_0051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/atrp_phase.sv =====
// Three-stage conversion of two angles (degrees, 8 fraction bits) to folded turn phases.
// Depends on atrp_pkg and angles_to_ray_point_macros.svh.
`include "angles_to_ray_point_macros.svh"
module atrp_phase #(
  parameter int SIDE_W = 4 * atrp_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [atrp_pkg::ANGLE_W-1:0]   ang [2],
  input  logic [SIDE_W-1:0]                     side_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output atrp_pkg::rot_t                        rot [2],
  output logic [SIDE_W-1:0]                     side_out
);

  localparam int NS = 3;
  localparam int PA_W = atrp_pkg::MAG_W + atrp_pkg::RECA_W;
  localparam int PB_W = atrp_pkg::QN_W + atrp_pkg::RECB_W;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_in;
  logic [NS:0]   en;

  // Stage 1: magnitude and coarse quotient by 45
  logic                               neg1 [2];
  logic [atrp_pkg::MAG_W-1:0]         mag1 [2];
  logic [PA_W-1:0]                    pa1  [2];
  logic                               neg1_r [2];
  logic [atrp_pkg::MAG_W-1:0]         mag1_r [2];
  logic [atrp_pkg::QA_W-1:0]          qa1_r  [2];
  logic [SIDE_W-1:0]                  side1_r;

  // Stage 2: remainder and fine quotient
  logic [atrp_pkg::QB_W-1:0]          qb2 [2];
  logic [atrp_pkg::QN_W-1:0]          qn2 [2];
  logic [PB_W-1:0]                    pb2 [2];
  logic                               neg2_r [2];
  logic [atrp_pkg::QA_W-1:0]          qa2_r  [2];
  logic [atrp_pkg::QLO_W-1:0]         qlo2_r [2];
  logic [SIDE_W-1:0]                  side2_r;

  // Stage 3: signed phase and fold into the right half plane
  logic [atrp_pkg::PHASE_W-1:0]       q3  [2];
  logic [atrp_pkg::PHASE_W-1:0]       p3  [2];
  logic [atrp_pkg::PHASE_W-1:0]       pq3 [2];
  atrp_pkg::rot_t                     rot_r [2];
  logic [SIDE_W-1:0]                  side3_r;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];
  assign v_in      = {v_r[NS-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      neg1[l] = ang[l][atrp_pkg::ANGLE_W-1];
      mag1[l] = neg1[l] ? atrp_pkg::MAG_W'(-ang[l]) : atrp_pkg::MAG_W'(ang[l]);
      pa1[l]  = PA_W'(mag1[l]) * PA_W'(atrp_pkg::REC45_A);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int l = 0; l < 2; l++) begin
        neg1_r[l] <= neg1[l];
        mag1_r[l] <= mag1[l];
        qa1_r[l]  <= atrp_pkg::QA_W'(pa1[l] >> atrp_pkg::RECA_SH);
      end
      side1_r <= side_in;
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qb2[l] = atrp_pkg::QB_W'(mag1_r[l] - atrp_pkg::MAG_W'(
                 atrp_pkg::MAG_W'(qa1_r[l]) * atrp_pkg::MAG_W'(atrp_pkg::DIV45)));
      qn2[l] = {qb2[l], atrp_pkg::QLO_W'(0)} + atrp_pkg::QN_W'(atrp_pkg::ROUND45);
      pb2[l] = PB_W'(qn2[l]) * PB_W'(atrp_pkg::REC45_B);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int l = 0; l < 2; l++) begin
        neg2_r[l] <= neg1_r[l];
        qa2_r[l]  <= qa1_r[l];
        qlo2_r[l] <= atrp_pkg::QLO_W'(pb2[l] >> atrp_pkg::RECB_SH);
      end
      side2_r <= side1_r;
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      q3[l]  = (atrp_pkg::PHASE_W'(qa2_r[l]) << atrp_pkg::QLO_W)
             + atrp_pkg::PHASE_W'(qlo2_r[l]);
      p3[l]  = neg2_r[l] ? (~q3[l] + atrp_pkg::PHASE_W'(1)) : q3[l];
      pq3[l] = p3[l] + atrp_pkg::PHASE_QUARTER;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int l = 0; l < 2; l++) begin
        rot_r[l].flip <= pq3[l][atrp_pkg::PHASE_W-1];
        rot_r[l].z    <= pq3[l][atrp_pkg::PHASE_W-1]
                       ? signed'(p3[l] + atrp_pkg::PHASE_HALF) : signed'(p3[l]);
      end
      side3_r <= side2_r;
    end
  end

  assign rot      = rot_r;
  assign side_out = side3_r;

  // An empty entry stage always takes a transaction
  `ATRP_ASSERT(a_ready_when_empty, !v_r[0], in_ready, "phase entry stage empty but not ready")

endmodule

// ===== rtl/atrp_cordic.sv =====
// Unrolled rotation-mode CORDIC, one register stage per iteration, two angle lanes.
// Depends on atrp_pkg and angles_to_ray_point_macros.svh.
`include "angles_to_ray_point_macros.svh"
module atrp_cordic #(
  parameter int STAGES = atrp_pkg::CORDIC_STAGES_DEF,
  parameter int SIDE_W = 4 * atrp_pkg::COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  atrp_pkg::rot_t       rot [2],
  input  logic [SIDE_W-1:0]    side_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output atrp_pkg::cs_t        cs [2],
  output logic [SIDE_W-1:0]    side_out
);

  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] v_in;
  logic [STAGES:0]   en;

  logic signed [atrp_pkg::XW-1:0] x_r [STAGES][2];
  logic signed [atrp_pkg::XW-1:0] y_r [STAGES][2];
  logic signed [atrp_pkg::ZW-1:0] z_r [STAGES][2];
  logic                           f_r [STAGES][2];
  logic [SIDE_W-1:0]              s_r [STAGES];

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[STAGES] = out_ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[STAGES-1];
  assign v_in      = {v_r[STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [atrp_pkg::XW-1:0] xi [2];
    logic signed [atrp_pkg::XW-1:0] yi [2];
    logic signed [atrp_pkg::ZW-1:0] zi [2];
    logic                           fi [2];
    logic [SIDE_W-1:0]              si;
    logic signed [atrp_pkg::ZW-1:0] at;

    // Select the stage input: fresh phase or previous iteration
    if (i == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 2; l++) begin
          xi[l] = atrp_pkg::XW'(atrp_pkg::GAIN_Q30);
          yi[l] = '0;
          zi[l] = atrp_pkg::ZW'(rot[l].z);
          fi[l] = rot[l].flip;
        end
        si = side_in;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < 2; l++) begin
          xi[l] = x_r[i-1][l];
          yi[l] = y_r[i-1][l];
          zi[l] = z_r[i-1][l];
          fi[l] = f_r[i-1][l];
        end
        si = s_r[i-1];
      end
    end

    assign at = signed'(atrp_pkg::ZW'(atrp_pkg::atan_turn(i)));

    // Rotate towards zero residual angle
    always_ff @(posedge clk) begin
      if (en[i]) begin
        for (int l = 0; l < 2; l++) begin
          if (!zi[l][atrp_pkg::ZW-1]) begin
            x_r[i][l] <= xi[l] - (yi[l] >>> i);
            y_r[i][l] <= yi[l] + (xi[l] >>> i);
            z_r[i][l] <= zi[l] - at;
          end else begin
            x_r[i][l] <= xi[l] + (yi[l] >>> i);
            y_r[i][l] <= yi[l] - (xi[l] >>> i);
            z_r[i][l] <= zi[l] + at;
          end
          f_r[i][l] <= fi[l];
        end
        s_r[i] <= si;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      cs[l].x    = x_r[STAGES-1][l];
      cs[l].y    = y_r[STAGES-1][l];
      cs[l].flip = f_r[STAGES-1][l];
    end
  end

  assign side_out = s_r[STAGES-1];

  // A finished transaction stays in the last stage until taken
  `ATRP_ASSERT_NEXT(a_last_hold, out_valid && !out_ready, out_valid, "cordic result dropped")

endmodule

// ===== rtl/atrp_ray.sv =====
// Direction products, distance scaling, offset add and saturation: six register stages.
// Depends on atrp_pkg and angles_to_ray_point_macros.svh.
`include "angles_to_ray_point_macros.svh"
module atrp_ray #(
  parameter int COORD_WIDTH = atrp_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  atrp_pkg::cs_t                  cs [2],
  input  logic [4*COORD_WIDTH-1:0]       side_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [COORD_WIDTH-1:0]  end_x,
  output logic signed [COORD_WIDTH-1:0]  end_y,
  output logic signed [COORD_WIDTH-1:0]  end_z,
  output logic                           saturated
);

  localparam int NS   = 6;
  localparam int CW   = COORD_WIDTH;
  localparam int DW   = atrp_pkg::DIR_W;
  localparam int MW   = 2 * DW;
  // Upper distance part keeps at least its sign bit
  localparam int HI_W = (CW > 16) ? CW - 16 : 1;
  localparam int PH_W = DW + HI_W;
  localparam int PL_W = DW + 17;
  localparam int FW   = CW + DW + 2;
  localparam int EW   = CW + 4;
  localparam int SW   = 4 * CW;
  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_in;
  logic [NS:0]   en;

  // Stage registers
  logic signed [DW-1:0] cp1_r, sp1_r, cy1_r, sy1_r;
  logic [SW-1:0]        side1_r;
  logic signed [MW-1:0] pxx2_r, pxy2_r;
  logic signed [DW-1:0] dz2_r;
  logic [SW-1:0]        side2_r;
  logic signed [DW-1:0] dir3_r [3];
  logic [SW-1:0]        side3_r;
  logic signed [PH_W-1:0] ph4_r [3];
  logic signed [PL_W-1:0] pl4_r [3];
  logic [SW-1:0]        side4_r;
  logic signed [EW-1:0] e5_r [3];
  logic signed [CW-1:0] end_r [3];
  logic                 sat_r;

  // Combinational helpers
  logic signed [CW-1:0]   st4   [3];
  logic signed [CW-1:0]   dist3;
  logic signed [HI_W-1:0] hi3;
  logic [15:0]            lo3;
  logic signed [FW-1:0]   full5 [3];
  logic signed [EW-1:0]   off5  [3];
  logic                   clip6 [3];
  logic signed [CW-1:0]   sv6   [3];
  logic                   on_lim;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];
  assign v_in      = {v_r[NS-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  // Stage 1: undo the half-turn fold
  always_ff @(posedge clk) begin
    if (en[0]) begin
      cp1_r   <= DW'(cs[0].flip ? -cs[0].x : cs[0].x);
      sp1_r   <= DW'(cs[0].flip ? -cs[0].y : cs[0].y);
      cy1_r   <= DW'(cs[1].flip ? -cs[1].x : cs[1].x);
      sy1_r   <= DW'(cs[1].flip ? -cs[1].y : cs[1].y);
      side1_r <= side_in;
    end
  end

  // Stage 2: cos pitch times cos and sin yaw, and negated sin pitch
  always_ff @(posedge clk) begin
    if (en[1]) begin
      pxx2_r  <= MW'(cp1_r) * MW'(cy1_r);
      pxy2_r  <= MW'(cp1_r) * MW'(sy1_r);
      dz2_r   <= -sp1_r;
      side2_r <= side1_r;
    end
  end

  // Stage 3: round direction back to Q2.30
  always_ff @(posedge clk) begin
    if (en[2]) begin
      dir3_r[0] <= DW'((pxx2_r + MW'(atrp_pkg::HALF_Q30)) >>> 30);
      dir3_r[1] <= DW'((pxy2_r + MW'(atrp_pkg::HALF_Q30)) >>> 30);
      dir3_r[2] <= dz2_r;
      side3_r   <= side2_r;
    end
  end

  // Stage 4: split distance into high and low partial products
  assign dist3 = signed'(side3_r[CW-1:0]);
  assign hi3   = HI_W'(dist3 >>> 16);
  assign lo3   = side3_r[15:0];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 3; k++) begin
        ph4_r[k] <= PH_W'(dir3_r[k]) * PH_W'(hi3);
        pl4_r[k] <= signed'(PL_W'(dir3_r[k]) * PL_W'({1'b0, lo3}));
      end
      side4_r <= side3_r;
    end
  end

  // Stage 5: recombine, round and add the start point
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      st4[k]   = signed'(side4_r[SW-1-k*CW -: CW]);
      full5[k] = (FW'(ph4_r[k]) <<< 16) + FW'(pl4_r[k]) + FW'(atrp_pkg::HALF_Q30);
      off5[k]  = EW'(full5[k] >>> 30);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int k = 0; k < 3; k++) begin
        e5_r[k] <= EW'(st4[k]) + off5[k];
      end
    end
  end

  // Stage 6: clip to the coordinate range
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      clip6[k] = (e5_r[k][EW-1:CW-1] != {(EW-CW+1){1'b0}})
              && (e5_r[k][EW-1:CW-1] != {(EW-CW+1){1'b1}});
      sv6[k]   = clip6[k] ? (e5_r[k][EW-1] ? MINV : MAXV) : CW'(e5_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int k = 0; k < 3; k++) begin
        end_r[k] <= sv6[k];
      end
      sat_r <= clip6[0] || clip6[1] || clip6[2];
    end
  end

  assign end_x     = end_r[0];
  assign end_y     = end_r[1];
  assign end_z     = end_r[2];
  assign saturated = sat_r;

  // Any coordinate sitting on a range limit
  assign on_lim = (end_x == MAXV) || (end_x == MINV) || (end_y == MAXV) || (end_y == MINV)
               || (end_z == MAXV) || (end_z == MINV);

  // A raised flag means at least one coordinate sits on a range limit
  `ATRP_ASSERT(a_sat_clip, out_valid && saturated, on_lim, "flag raised, nothing clipped")

endmodule

// ===== rtl/angles_to_ray_point.sv =====
// Top level of the ray point block: angle conversion, CORDIC and ray scaling pipelines.
// Depends on atrp_pkg, atrp_phase, atrp_cordic and atrp_ray.

// Extends a ray from a start point along the direction given by pitch and yaw
// (degrees, 8 fraction bits) by a signed Q16.16 distance, and returns the
// saturated end point with a flag that is set when any coordinate clipped.
// The block is a fully pipelined datapath that takes one transaction every
// cycle while the output is not held; each transaction passes through 3 phase
// stages, one stage per CORDIC iteration and 6 ray stages.
// Every stage has its own valid bit and moves up whenever the stage ahead of
// it is free, so bubbles close up and a result held at the output does not
// block accepting new transactions until the pipeline is full.
module angles_to_ray_point #(
  parameter int CORDIC_STAGES = atrp_pkg::CORDIC_STAGES_DEF,
  parameter int COORD_WIDTH   = atrp_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [atrp_pkg::ANGLE_W-1:0]  in_pitch_deg,
  input  logic signed [atrp_pkg::ANGLE_W-1:0]  in_yaw_deg,
  input  logic signed [COORD_WIDTH-1:0]        in_start_x,
  input  logic signed [COORD_WIDTH-1:0]        in_start_y,
  input  logic signed [COORD_WIDTH-1:0]        in_start_z,
  input  logic signed [COORD_WIDTH-1:0]        in_distance,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [COORD_WIDTH-1:0]        out_end_x,
  output logic signed [COORD_WIDTH-1:0]        out_end_y,
  output logic signed [COORD_WIDTH-1:0]        out_end_z,
  output logic                                 out_saturated
);

  localparam int SIDE_W = 4 * COORD_WIDTH;

  logic signed [atrp_pkg::ANGLE_W-1:0] ang [2];
  logic [SIDE_W-1:0]                   side_in;
  logic                                ph_valid, ph_ready;
  atrp_pkg::rot_t                      rot [2];
  logic [SIDE_W-1:0]                   ph_side;
  logic                                cs_valid, cs_ready;
  atrp_pkg::cs_t                       cs [2];
  logic [SIDE_W-1:0]                   cs_side;

  // Pack the angles and the pass-through coordinates
  assign ang[0]  = in_pitch_deg;
  assign ang[1]  = in_yaw_deg;
  assign side_in = {in_start_x, in_start_y, in_start_z, in_distance};

  atrp_phase #(
    .SIDE_W (SIDE_W)
  ) u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ang       (ang),
    .side_in   (side_in),
    .out_valid (ph_valid),
    .out_ready (ph_ready),
    .rot       (rot),
    .side_out  (ph_side)
  );

  atrp_cordic #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W (SIDE_W)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ph_valid),
    .in_ready  (ph_ready),
    .rot       (rot),
    .side_in   (ph_side),
    .out_valid (cs_valid),
    .out_ready (cs_ready),
    .cs        (cs),
    .side_out  (cs_side)
  );

  atrp_ray #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_ray (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cs_valid),
    .in_ready  (cs_ready),
    .cs        (cs),
    .side_in   (cs_side),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .end_x     (out_end_x),
    .end_y     (out_end_y),
    .end_z     (out_end_z),
    .saturated (out_saturated)
  );

endmodule

// ===== tb/angles_to_ray_point_test.sv =====
// Self-checking bench for angles_to_ray_point: predicts each end point from angles and distance.
// Depends on atrp_pkg and the angles_to_ray_point RTL only.
module angles_to_ray_point_test;
  import atrp_pkg::*;

  localparam int CW      = COORD_WIDTH_DEF;
  localparam int STAGES  = CORDIC_STAGES_DEF;
  localparam int LATENCY = STAGES + 9;
  localparam int N_RAND  = 750;

  typedef struct {
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] yaw;
    logic signed [CW-1:0]      sx, sy, sz, distance;
  } ray_query_t;

  typedef struct {
    logic signed [CW-1:0] ex, ey, ez;
    logic                 sat;
  } ray_point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [ANGLE_W-1:0] in_pitch_deg = '0, in_yaw_deg = '0;
  logic signed [CW-1:0] in_start_x = '0, in_start_y = '0, in_start_z = '0, in_distance = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CW-1:0] out_end_x, out_end_y, out_end_z;
  logic out_saturated;

  ray_query_t query_q[$];
  ray_point_t point_q[$];
  int mismatches = 0;
  bit feeding_done = 0;
  bit hold_sender = 0;
  int send_gap = 0, recv_gap = 0;

  angles_to_ray_point i_dut (.*);

  always #10 clk = ~clk;

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  // Sine and cosine in Q2.30 of one angle, CORDIC with fold past a quarter turn
  function automatic void cordic_sin_cos(logic signed [ANGLE_W-1:0] ang,
                                         output longint s, output longint c);
    longint a, mag, x, y, z, xs, ys;
    logic [31:0] q, p;
    bit flip;
    a = ang;
    mag = a < 0 ? -a : a;
    q = 32'((mag * 64'd16777216 + 180) / 360);
    p = a < 0 ? (~q + 32'd1) : q;
    flip = (32'(p + PHASE_QUARTER) & PHASE_HALF) != 0;
    if (flip) p = p + PHASE_HALF;
    z = longint'($signed(p));
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
      xs = shr(x, i);
      ys = shr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_turn(i));
      end else begin
        x += ys; y -= xs; z += longint'(atan_turn(i));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endfunction

  // Exact round(d * span / 2^30), halves up, split to stay within 64 bits
  function automatic longint scale_by_distance(longint d, longint span);
    longint hi, lo, a, ahi, alo;
    hi = shr(span, 16);
    lo = span - hi * 65536;
    a = d * hi;
    ahi = shr(a, 14);
    alo = a - ahi * 16384;
    return ahi + shr(alo * 65536 + d * lo + HALF_Q30, 30);
  endfunction

  function automatic ray_point_t predict_ray_point(ray_query_t t);
    ray_point_t r;
    longint sp, cp, sy, cy, e;
    longint dir[3], st[3], res[3];
    longint maxv, minv;
    maxv = (longint'(1) << (CW - 1)) - 1;
    minv = -maxv - 1;
    cordic_sin_cos(t.pitch, sp, cp);
    cordic_sin_cos(t.yaw, sy, cy);
    dir[0] = shr(cp * cy + HALF_Q30, 30);
    dir[1] = shr(cp * sy + HALF_Q30, 30);
    dir[2] = -sp;
    st[0] = t.sx; st[1] = t.sy; st[2] = t.sz;
    r.sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      e = st[k] + scale_by_distance(dir[k], t.distance);
      if (e > maxv) begin
        e = maxv; r.sat = 1'b1;
      end else if (e < minv) begin
        e = minv; r.sat = 1'b1;
      end
      res[k] = e;
    end
    r.ex = CW'(res[0]); r.ey = CW'(res[1]); r.ez = CW'(res[2]);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return {CW{1'b0}} | $urandom_range(0, 32'h00FF_FFFF);
      2: return -($urandom_range(0, 32'h00FF_FFFF));
      3: return $urandom_range(0, 1) ? 32'sh7FFF_0000 + $urandom_range(0, 65535)
                                     : 32'sh8000_0000 + $urandom_range(0, 65535);
      default: return $signed($urandom) >>> $urandom_range(0, 20);
    endcase
  endfunction

  function automatic logic signed [ANGLE_W-1:0] rand_angle();
    case ($urandom_range(0, 4))
      0: return ANGLE_W'($urandom_range(0, 92160) - 46080);
      1: return $urandom_range(0, 1) ? ANGLE_W'(46080 - $urandom_range(0, 3))
                                     : ANGLE_W'(-46080 + $urandom_range(0, 3));
      2: return ANGLE_W'((90 * 256) * ($urandom_range(0, 8) - 4) + $urandom_range(0, 2) - 1);
      3: return ANGLE_W'($urandom_range(0, 1024) - 512);
      default: return ANGLE_W'($urandom_range(0, 46080 * 2) - 46080);
    endcase
  endfunction

  function automatic ray_query_t make_query(int p, int y, longint x0, longint y0,
                                            longint z0, longint d);
    ray_query_t t;
    t.pitch = ANGLE_W'(p); t.yaw = ANGLE_W'(y);
    t.sx = CW'(x0); t.sy = CW'(y0); t.sz = CW'(z0); t.distance = CW'(d);
    return t;
  endfunction

  // Fill the query queue: directed corners first, then random rays, then a final directed ray
  initial begin
    ray_query_t t;
    longint mx, mn;
    mx = 64'sh7FFF_FFFF;
    mn = -64'sh8000_0000;
    query_q.push_back(make_query(0, 0, 0, 0, 0, 0));
    query_q.push_back(make_query(0, 0, 0, 0, 0, 32'sh0001_0000));
    query_q.push_back(make_query(46080, 46080, 0, 0, 0, 32'sh0010_0000));
    query_q.push_back(make_query(-46080, -46080, 0, 0, 0, 32'sh0010_0000));
    query_q.push_back(make_query(23040, 0, 0, 0, 0, 32'sh0100_0000));
    query_q.push_back(make_query(-23040, 0, 0, 0, 0, 32'sh0100_0000));
    query_q.push_back(make_query(23041, 23039, 5, -5, 7, 32'sh0002_8000));
    query_q.push_back(make_query(-23041, -23039, 5, -5, 7, 32'sh0002_8000));
    query_q.push_back(make_query(0, 23040, 0, 0, 0, mx));
    query_q.push_back(make_query(0, 23041, 0, 0, 0, mn));
    query_q.push_back(make_query(0, 0, mx, 0, 0, mx));
    query_q.push_back(make_query(0, 0, mn, 0, 0, mn));
    query_q.push_back(make_query(-23040, 0, 0, 0, mx, mx));
    query_q.push_back(make_query(23040, 0, 0, 0, mn, mx));
    query_q.push_back(make_query(0, 11520, mx, mx, mx, mx));
    query_q.push_back(make_query(0, -11520, mn, mn, mn, mn));
    query_q.push_back(make_query(65535, -65536, mx, mn, 1, -1));
    query_q.push_back(make_query(-1, 1, -1, 1, -1, 1));
    query_q.push_back(make_query(11520, 34560, 32'sh1234_5678, -32'sh0765_4321, 0,
                                 -32'sh0040_0000));
    for (int i = 0; i < N_RAND; i++) begin
      t.pitch = rand_angle();
      t.yaw = rand_angle();
      t.sx = rand_coord(); t.sy = rand_coord(); t.sz = rand_coord();
      t.distance = rand_coord();
      query_q.push_back(t);
    end
    // full-range bit toggles on the raw angle ports
    query_q.push_back(make_query(-65536, 65535, 0, 0, 0, 32'sh0000_1000));
  end

  // Hold reset, then release it
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: present queued queries, hold each until accepted, drain once midway
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        point_q.push_back(predict_ray_point(query_q.pop_front()));
        if (query_q.size() == 400) hold_sender = 1;
      end
      if (hold_sender && point_q.size() == 0) hold_sender = 0;
      if (!(in_valid && !in_ready)) begin
        if (send_gap > 0) send_gap--;
        if (query_q.size() > 0 && send_gap == 0 && !hold_sender &&
            !(in_valid && in_ready && query_q.size() == 0)) begin
          in_valid <= 1'b1;
          in_pitch_deg <= query_q[0].pitch;
          in_yaw_deg <= query_q[0].yaw;
          in_start_x <= query_q[0].sx;
          in_start_y <= query_q[0].sy;
          in_start_z <= query_q[0].sz;
          in_distance <= query_q[0].distance;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
        if (query_q.size() == 0) feeding_done <= 1'b1;
      end
    end
  end

  // Monitor: compare each accepted point with the oldest prediction
  always @(posedge clk) begin
    ray_point_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (point_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected point %0d %0d %0d sat %0b",
                                         out_end_x, out_end_y, out_end_z, out_saturated);
        end else begin
          want = point_q.pop_front();
          if (want.ex !== out_end_x || want.ey !== out_end_y || want.ez !== out_end_z ||
              want.sat !== out_saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("point mismatch: want %0d %0d %0d sat %0b, got %0d %0d %0d sat %0b",
                       want.ex, want.ey, want.ez, want.sat,
                       out_end_x, out_end_y, out_end_z, out_saturated);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // Finish once all queries are in and every prediction is matched
  initial begin
    wait (feeding_done && !in_valid && point_q.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && point_q.size() == 0)
      $display("angles_to_ray_point_test: done, clean");
    else
      $display("angles_to_ray_point_test: done, errors");
    $finish;
  end

  // Timeout guard
  initial begin
    #4000000;
    $display("angles_to_ray_point_test: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/atrp_pkg.sv
rtl/atrp_phase.sv
rtl/atrp_cordic.sv
rtl/atrp_ray.sv
rtl/angles_to_ray_point.sv
tb/angles_to_ray_point_test.sv
